@@ rtl/core/hsc_pkg.sv @@
// Shared types, codes and position helpers for the Hamming SEC codec.
package hsc_pkg;

  localparam int POS_W  = 71;
  localparam int DATA_W = 64;
  localparam int SYN_W  = 7;

  localparam logic ACT_ENCODE = 1'b0;
  localparam logic ACT_DECODE = 1'b1;

  typedef logic [POS_W-1:0] cw_t;

  typedef struct packed {
    logic             action;
    logic [SYN_W-1:0] n;
    cw_t              cw;
  } front_t;

  typedef struct packed {
    logic             action;
    logic [SYN_W-1:0] n;
    logic [SYN_W-1:0] syn;
    cw_t              cw;
  } synd_t;

  typedef struct packed {
    logic              uncorrectable;
    logic              corrected;
    logic [SYN_W-1:0]  syndrome;
    logic [6:0]        result_high;
    logic [DATA_W-1:0] result_low;
  } result_t;

  function automatic logic is_pow2(input int v);
    return (v != 0) && ((v & (v - 1)) == 0);
  endfunction

  // Codeword length for a clamped data width k.
  function automatic logic [SYN_W-1:0] code_len(input logic [SYN_W-1:0] k);
    logic [SYN_W-1:0] l;
    if (k <= 7'd1) begin
      l = 7'd2;
    end else if (k <= 7'd4) begin
      l = 7'd3;
    end else if (k <= 7'd11) begin
      l = 7'd4;
    end else if (k <= 7'd26) begin
      l = 7'd5;
    end else if (k <= 7'd57) begin
      l = 7'd6;
    end else begin
      l = 7'd7;
    end
    return k + l;
  endfunction

  // Data bits go to the positions that are not powers of two, in order.
  function automatic cw_t scatter(input logic [DATA_W-1:0] data);
    cw_t res;
    int  d;
    res = '0;
    d   = 0;
    for (int i = 1; i <= POS_W; i++) begin
      if (!is_pow2(i)) begin
        res[i-1] = data[d[5:0]];
        d++;
      end
    end
    return res;
  endfunction

  function automatic logic [DATA_W-1:0] gather(input cw_t cw);
    logic [DATA_W-1:0] res;
    int                d;
    res = '0;
    d   = 0;
    for (int i = 1; i <= POS_W; i++) begin
      if (!is_pow2(i)) begin
        res[d[5:0]] = cw[i-1];
        d++;
      end
    end
    return res;
  endfunction

endpackage

@@ rtl/core/hsc_frontend.sv @@
// First stage: clamps the width, places the word on codeword positions and masks beyond n.
module hsc_frontend #(
  parameter int MAX_DATA_BITS = 64
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     in_action,
  input  hsc_pkg::cw_t             in_word,
  input  logic [hsc_pkg::SYN_W-1:0] data_bits,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hsc_pkg::front_t          out_item
);

  localparam logic [hsc_pkg::SYN_W-1:0] KMAX = hsc_pkg::SYN_W'(MAX_DATA_BITS);

  logic                      valid_r;
  hsc_pkg::front_t           item_r;
  hsc_pkg::front_t           item_nxt;
  logic [hsc_pkg::SYN_W-1:0] k_eff;
  logic [hsc_pkg::SYN_W-1:0] n;
  hsc_pkg::cw_t              raw;
  hsc_pkg::cw_t              mask;

  always_comb begin
    if (data_bits == '0) begin
      k_eff = 7'd1;
    end else if (data_bits > KMAX) begin
      k_eff = KMAX;
    end else begin
      k_eff = data_bits;
    end
    n = hsc_pkg::code_len(k_eff);
    for (int i = 0; i < hsc_pkg::POS_W; i++) begin
      mask[i] = (7'(i + 1) <= n);
    end
    raw = (in_action == hsc_pkg::ACT_DECODE) ? in_word
        : hsc_pkg::scatter(in_word[hsc_pkg::DATA_W-1:0]);
    item_nxt.action = in_action;
    item_nxt.n      = n;
    item_nxt.cw     = raw & mask;
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/core/hsc_syndrome.sv @@
// Second stage: XOR trees over the masked codeword that form the parity checks.
module hsc_syndrome (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  hsc_pkg::front_t in_item,
  output logic            out_valid,
  input  logic            out_ready,
  output hsc_pkg::synd_t  out_item
);

  logic           valid_r;
  hsc_pkg::synd_t item_r;
  hsc_pkg::synd_t item_nxt;
  hsc_pkg::cw_t   col;

  always_comb begin
    item_nxt.action = in_item.action;
    item_nxt.n      = in_item.n;
    item_nxt.cw     = in_item.cw;
    for (int j = 0; j < hsc_pkg::SYN_W; j++) begin
      for (int i = 0; i < hsc_pkg::POS_W; i++) begin
        col[i] = (((i + 1) >> j) & 1) != 0;
      end
      item_nxt.syn[j] = ^(in_item.cw & col);
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/core/hsc_backend.sv @@
// Third stage: inserts parity bits or corrects and extracts data, then holds the result.
module hsc_backend (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  hsc_pkg::synd_t   in_item,
  output logic             out_valid,
  input  logic             out_ready,
  output hsc_pkg::result_t out_item
);

  logic             valid_r;
  hsc_pkg::result_t item_r;
  hsc_pkg::result_t item_nxt;
  hsc_pkg::cw_t     enc_cw;
  hsc_pkg::cw_t     fix_cw;
  hsc_pkg::cw_t     flip;
  logic             in_range;

  always_comb begin
    enc_cw = in_item.cw;
    for (int j = 0; j < hsc_pkg::SYN_W; j++) begin
      enc_cw[(1 << j) - 1] = in_item.syn[j];
    end
    in_range = (in_item.syn != '0) && (in_item.syn <= in_item.n);
    flip     = '0;
    for (int i = 0; i < hsc_pkg::POS_W; i++) begin
      flip[i] = in_range && (in_item.syn == 7'(i + 1));
    end
    fix_cw = in_item.cw ^ flip;
    if (in_item.action == hsc_pkg::ACT_DECODE) begin
      item_nxt.result_low    = hsc_pkg::gather(fix_cw);
      item_nxt.result_high   = '0;
      item_nxt.syndrome      = in_item.syn;
      item_nxt.corrected     = in_range;
      item_nxt.uncorrectable = (in_item.syn > in_item.n);
    end else begin
      item_nxt.result_low    = enc_cw[hsc_pkg::DATA_W-1:0];
      item_nxt.result_high   = enc_cw[hsc_pkg::POS_W-1:hsc_pkg::DATA_W];
      item_nxt.syndrome      = '0;
      item_nxt.corrected     = 1'b0;
      item_nxt.uncorrectable = 1'b0;
    end
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_item  = item_r;

endmodule

@@ rtl/core/hamming_sec_codec_unit.sv @@
// Top level of the Hamming single-error-correcting codec with its width register.
//
// Items enter on the in_ stream: in_tuser selects encode (0) or decode (1), and
// in_tdata carries the data word or the packed codeword, position 1 in bit 0.
// Results leave on the out_ stream as one item per input item, in order.
// The cfg_ channel writes the data width k; it is always ready and should only
// be written while no item is in flight. Values of 0 act as 1 and values above
// MAX_DATA_BITS act as MAX_DATA_BITS.
// The datapath has three register stages: placement and masking, the parity
// check XOR trees, then correction, parity insertion and the output register.
// A result passes the frontend, syndrome and backend registers in turn before it is
// valid on out_. One item can be accepted in every cycle while out_tready is high,
// so sustained throughput is one item per cycle.
// When out_tready is low the stages fill up one by one and in_tready drops
// only once all three hold an item; nothing is dropped or repeated.
// Reset empties the pipeline and sets k to 8.
module hamming_sec_codec_unit #(
  parameter int MAX_DATA_BITS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // word_low[63:0], word_high[70:64], zero pad[71]
  input  logic        in_tuser,   // action
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // result_low, result_high, syndrome, corrected,
                                  // uncorrectable
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [6:0]  cfg_data    // data_bits
);

  logic [hsc_pkg::SYN_W-1:0] data_bits_r;
  logic                      fe_valid;
  logic                      fe_ready;
  hsc_pkg::front_t           fe_item;
  logic                      sy_valid;
  logic                      sy_ready;
  hsc_pkg::synd_t            sy_item;
  hsc_pkg::result_t          res_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_bits_r <= 7'd8;
    end else if (cfg_valid && cfg_ready) begin
      data_bits_r <= cfg_data;
    end
  end

  hsc_frontend #(
    .MAX_DATA_BITS(MAX_DATA_BITS)
  ) u_frontend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_action (in_tuser),
    .in_word   (in_tdata[hsc_pkg::POS_W-1:0]),
    .data_bits (data_bits_r),
    .out_valid (fe_valid),
    .out_ready (fe_ready),
    .out_item  (fe_item)
  );

  hsc_syndrome u_syndrome (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fe_valid),
    .in_ready  (fe_ready),
    .in_item   (fe_item),
    .out_valid (sy_valid),
    .out_ready (sy_ready),
    .out_item  (sy_item)
  );

  hsc_backend u_backend (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (sy_valid),
    .in_ready  (sy_ready),
    .in_item   (sy_item),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_item  (res_item)
  );

  assign out_tdata = res_item;

endmodule
